[sv/bbcm_pkg.sv]
package bbcm_pkg;
  localparam int DefEntries = 64;
  localparam int DefBlockBits = 24;
  localparam int DefCountBits = 8;

  typedef enum logic [2:0] {
    OP_GET = 3'd0,
    OP_RELEASE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_INVAL = 3'd3,
    OP_SYNC = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    ST_HIT = 4'd0,
    ST_ALLOC = 4'd1,
    ST_NO_FREE = 4'd2,
    ST_VICT_LOCKED = 4'd3,
    ST_VICT_DIRTY = 4'd4,
    ST_RELEASED = 4'd5,
    ST_REL_ERROR = 4'd6,
    ST_REL_BUSY = 4'd7,
    ST_FLAGS_SET = 4'd8,
    ST_INVALIDATED = 4'd9,
    ST_DIRTY_ENTRY = 4'd10,
    ST_NONE_DIRTY = 4'd11,
    ST_COUNT_OVF = 4'd12
  } status_t;
endpackage

[sv/block_buffer_cache_manager.sv]
// channel | handshake             | fields
// in      | in_valid / in_stall   | opcode device block_number entry_index all_devices new_*
// out     | out_valid / out_stall | status result_index result_uptodate result_locked last
// one word at a time
// miss: tag scan, recency walk, then for a clean victim write and shift to tail
// reset starts a clearing pass over all entries before the first word is taken
// a result waiting under out_stall holds off the next word
module block_buffer_cache_manager
  import bbcm_pkg::*;
#(
  parameter int ENTRIES = DefEntries,
  parameter int BLOCK_BITS = DefBlockBits,
  parameter int COUNT_BITS = DefCountBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [15:0] device,
  input  logic [23:0] block_number,
  input  logic [5:0]  entry_index,
  input  logic        all_devices,
  input  logic        new_dirty,
  input  logic        new_locked,
  input  logic        new_uptodate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [5:0]  result_index,
  output logic        result_uptodate,
  output logic        result_locked,
  output logic        last
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [6:0] NENT = 7'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef struct packed {
    logic [15:0] dev;
    logic [BLOCK_BITS-1:0] blk;
    logic [COUNT_BITS-1:0] cnt;
    logic dirty;
    logic locked;
    logic upd;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SYNC_END, S_WALK_REC, S_WALK_ENT,
    S_WALK_CHK, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR, S_OUT
  } state_t;

  entry_t ent_mem [ENTRIES];
  logic [IW-1:0] rec_mem [ENTRIES];
  entry_t ent_rd;
  logic [IW-1:0] rec_rd;

  logic ent_we;
  logic [IW-1:0] ent_wa, ent_ra;
  entry_t ent_wd;
  logic rec_we;
  logic [IW-1:0] rec_wa, rec_ra, rec_wd;

  state_t state, ret;
  opcode_t op;
  logic [15:0] dev;
  logic [BLOCK_BITS-1:0] blk;
  logic idx_ok;
  logic all_dev, nd, nl, nu;
  logic [IW-1:0] ptr;
  logic found;
  logic [IW-1:0] best;
  logic [1:0] best_bad;
  logic best_up, best_lk;
  logic [IW-1:0] best_pos;

  logic [1:0] bad;
  logic is_hit, sync_hit, ovf, take;

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd <= ent_mem[ent_ra];
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd <= rec_mem[rec_ra];
  end

  assign bad = {ent_rd.dirty, ent_rd.locked};
  assign is_hit = (dev != 16'd0) && (ent_rd.dev == dev) && (ent_rd.blk == blk);
  assign sync_hit = (ent_rd.dev != 16'd0) && (all_dev || ent_rd.dev == dev) && ent_rd.dirty;
  assign ovf = ent_rd.cnt == CMAX;
  assign take = (ent_rd.cnt == '0) && (!found || bad < best_bad);

  // memory port control
  always_comb begin
    ent_we = 1'b0;
    ent_wa = ptr;
    ent_wd = ent_rd;
    ent_ra = ptr;
    rec_we = 1'b0;
    rec_wa = ptr;
    rec_wd = rec_rd;
    rec_ra = ptr;
    case (state)
      S_CLEAR: begin
        ent_we = 1'b1;
        ent_wd = '0;
        rec_we = 1'b1;
        rec_wd = ptr;
      end
      S_SCAN_CHK: begin
        case (op)
          OP_GET: begin
            if (is_hit && !ovf) begin
              ent_we = 1'b1;
              ent_wd.cnt = ent_rd.cnt + COUNT_BITS'(1);
            end
          end
          OP_RELEASE: begin
            if (idx_ok && ent_rd.cnt != '0 && !ent_rd.locked) begin
              ent_we = 1'b1;
              ent_wd.cnt = ent_rd.cnt - COUNT_BITS'(1);
            end
          end
          OP_UPDATE: begin
            if (idx_ok) begin
              ent_we = 1'b1;
              ent_wd.dirty = nd;
              ent_wd.locked = nl;
              ent_wd.upd = nu;
            end
          end
          OP_INVAL: begin
            if (dev != 16'd0 && ent_rd.dev == dev) begin
              ent_we = 1'b1;
              ent_wd.upd = 1'b0;
              ent_wd.dirty = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_WALK_ENT: ent_ra = rec_rd;
      S_DECIDE: begin
        if (found && best_bad == 2'd0) begin
          ent_we = 1'b1;
          ent_wa = best;
          ent_wd = '0;
          ent_wd.dev = dev;
          ent_wd.blk = blk;
          ent_wd.cnt = COUNT_BITS'(1);
        end
      end
      S_SHIFT_RD: begin
        if (ptr == LAST) begin
          rec_we = 1'b1;
          rec_wd = best;
        end else begin
          rec_ra = ptr + IW'(1);
        end
      end
      S_SHIFT_WR: rec_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ret <= S_IDLE;
      ptr <= '0;
      found <= 1'b0;
      in_stall <= 1'b1;
      out_valid <= 1'b0;
      status <= ST_HIT;
      result_index <= '0;
      result_uptodate <= 1'b0;
      result_locked <= 1'b0;
      last <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (ptr == LAST) begin
            ptr <= '0;
            state <= S_IDLE;
            in_stall <= 1'b0;
          end else begin
            ptr <= ptr + IW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op <= opcode_t'(opcode);
            dev <= device;
            blk <= BLOCK_BITS'(block_number);
            idx_ok <= {1'b0, entry_index} < NENT;
            all_dev <= all_devices;
            nd <= new_dirty;
            nl <= new_locked;
            nu <= new_uptodate;
            found <= 1'b0;
            if (opcode <= OP_SYNC) begin
              in_stall <= 1'b1;
              state <= S_SCAN_RD;
              if (opcode == OP_RELEASE || opcode == OP_UPDATE) ptr <= IW'(entry_index);
              else ptr <= '0;
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          case (op)
            OP_GET: begin
              if (is_hit) begin
                out_valid <= 1'b1;
                status <= ovf ? ST_COUNT_OVF : ST_HIT;
                result_index <= 6'(ptr);
                result_uptodate <= ent_rd.upd;
                result_locked <= ent_rd.locked;
                last <= 1'b1;
                ret <= S_IDLE;
                state <= S_OUT;
              end else if (ptr == LAST) begin
                ptr <= '0;
                state <= S_WALK_REC;
              end else begin
                ptr <= ptr + IW'(1);
                state <= S_SCAN_RD;
              end
            end
            OP_RELEASE: begin
              out_valid <= 1'b1;
              if (!idx_ok || ent_rd.cnt == '0) status <= ST_REL_ERROR;
              else if (ent_rd.locked) status <= ST_REL_BUSY;
              else status <= ST_RELEASED;
              result_index <= idx_ok ? 6'(ptr) : 6'd0;
              result_uptodate <= idx_ok & ent_rd.upd;
              result_locked <= idx_ok & ent_rd.locked;
              last <= 1'b1;
              ret <= S_IDLE;
              state <= S_OUT;
            end
            OP_UPDATE: begin
              out_valid <= 1'b1;
              status <= idx_ok ? ST_FLAGS_SET : ST_REL_ERROR;
              result_index <= idx_ok ? 6'(ptr) : 6'd0;
              result_uptodate <= idx_ok & nu;
              result_locked <= idx_ok & nl;
              last <= 1'b1;
              ret <= S_IDLE;
              state <= S_OUT;
            end
            OP_INVAL: begin
              if (ptr == LAST) begin
                out_valid <= 1'b1;
                status <= ST_INVALIDATED;
                result_index <= '0;
                result_uptodate <= 1'b0;
                result_locked <= 1'b0;
                last <= 1'b1;
                ret <= S_IDLE;
                state <= S_OUT;
              end else begin
                ptr <= ptr + IW'(1);
                state <= S_SCAN_RD;
              end
            end
            OP_SYNC: begin
              // a found entry is held back until the next one shows whether it is the last
              ptr <= ptr + IW'(1);
              if (sync_hit) begin
                found <= 1'b1;
                best <= ptr;
                best_up <= ent_rd.upd;
                best_lk <= ent_rd.locked;
              end
              if (sync_hit && found) begin
                out_valid <= 1'b1;
                status <= ST_DIRTY_ENTRY;
                result_index <= 6'(best);
                result_uptodate <= best_up;
                result_locked <= best_lk;
                last <= 1'b0;
                ret <= (ptr == LAST) ? S_SYNC_END : S_SCAN_RD;
                state <= S_OUT;
              end else begin
                state <= (ptr == LAST) ? S_SYNC_END : S_SCAN_RD;
              end
            end
            default: begin
              state <= S_IDLE;
              in_stall <= 1'b0;
            end
          endcase
        end
        S_SYNC_END: begin
          out_valid <= 1'b1;
          status <= found ? ST_DIRTY_ENTRY : ST_NONE_DIRTY;
          result_index <= found ? 6'(best) : 6'd0;
          result_uptodate <= found & best_up;
          result_locked <= found & best_lk;
          last <= 1'b1;
          ret <= S_IDLE;
          state <= S_OUT;
        end
        S_WALK_REC: state <= S_WALK_ENT;
        S_WALK_ENT: state <= S_WALK_CHK;
        S_WALK_CHK: begin
          if (take) begin
            found <= 1'b1;
            best <= rec_rd;
            best_bad <= bad;
            best_up <= ent_rd.upd;
            best_pos <= ptr;
          end
          if ((take && bad == 2'd0) || ptr == LAST) begin
            state <= S_DECIDE;
          end else begin
            ptr <= ptr + IW'(1);
            state <= S_WALK_REC;
          end
        end
        S_DECIDE: begin
          out_valid <= 1'b1;
          last <= 1'b1;
          state <= S_OUT;
          if (!found) begin
            status <= ST_NO_FREE;
            result_index <= '0;
            result_uptodate <= 1'b0;
            result_locked <= 1'b0;
            ret <= S_IDLE;
          end else if (best_bad[0]) begin
            status <= ST_VICT_LOCKED;
            result_index <= 6'(best);
            result_uptodate <= best_up;
            result_locked <= 1'b1;
            ret <= S_IDLE;
          end else if (best_bad[1]) begin
            status <= ST_VICT_DIRTY;
            result_index <= 6'(best);
            result_uptodate <= best_up;
            result_locked <= 1'b0;
            ret <= S_IDLE;
          end else begin
            status <= ST_ALLOC;
            result_index <= 6'(best);
            result_uptodate <= 1'b0;
            result_locked <= 1'b0;
            ret <= S_SHIFT_RD;
            ptr <= best_pos;
          end
        end
        // recency shift: from the victim's place to the tail
        S_SHIFT_RD: begin
          if (ptr == LAST) begin
            state <= S_IDLE;
            in_stall <= 1'b0;
          end else begin
            state <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          ptr <= ptr + IW'(1);
          state <= S_SHIFT_RD;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= ret;
            if (ret == S_IDLE) in_stall <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result while accepting");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall) else $error("accept during clear");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_COUNT_OVF)) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(result_index)
    && $stable(last))) else $error("stalled word changed");
`endif
endmodule

[test/tb.sv]
module tb;
  import bbcm_pkg::*;

  localparam int N = DefEntries;
  localparam logic [7:0] CountMax = 8'hFF;

  typedef struct {
    status_t st;
    logic [5:0] idx;
    logic up;
    logic lk;
    logic lst;
  } word_t;

  typedef struct {
    logic [2:0] op;
    logic [15:0] dev;
    logic [23:0] blk;
    logic [5:0] idx;
    logic all, d, l, u;
    bit chk;
    status_t st;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] opcode = 0;
  logic [15:0] device = 0;
  logic [23:0] block_number = 0;
  logic [5:0] entry_index = 0;
  logic all_devices = 0, new_dirty = 0, new_locked = 0, new_uptodate = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [3:0] status;
  logic [5:0] result_index;
  logic result_uptodate, result_locked, last;

  block_buffer_cache_manager DUT (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [15:0] cache_dev[N];
  logic [23:0] cache_blk[N];
  logic [7:0] cache_cnt[N];
  logic cache_dirty[N], cache_lock[N], cache_up[N];
  logic [5:0] lru_order[N];

  word_t pending_words[$];
  int errors = 0;
  int words_seen = 0;
  int items_sent = 0;
  bit quiet = 0;
  int stall_left = 0;
  row_t table_rows[$];

  task automatic report(string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  function automatic word_t mk(status_t s, int e, bit with_entry);
    word_t w;
    w.st = s;
    w.lst = 0;
    if (with_entry) begin
      w.idx = e[5:0];
      w.up = cache_up[e];
      w.lk = cache_lock[e];
    end else begin
      w.idx = 0;
      w.up = 0;
      w.lk = 0;
    end
    return w;
  endfunction

  task automatic cache_get(row_t r, ref word_t res[$]);
    int best, pos;
    logic [1:0] bad, best_bad;
    logic [5:0] c;
    best = -1;
    best_bad = 0;
    if (r.dev != 0) begin
      for (int e = 0; e < N; e++) begin
        if (cache_dev[e] == r.dev && cache_blk[e] == r.blk) begin
          if (cache_cnt[e] == CountMax) begin
            res.push_back(mk(ST_COUNT_OVF, e, 1));
          end else begin
            cache_cnt[e]++;
            res.push_back(mk(ST_HIT, e, 1));
          end
          return;
        end
      end
    end
    for (int p = 0; p < N; p++) begin
      c = lru_order[p];
      if (cache_cnt[c] != 0) continue;
      bad = {cache_dirty[c], cache_lock[c]};
      if (best < 0 || bad < best_bad) begin
        best = c;
        best_bad = bad;
        if (bad == 0) break;
      end
    end
    if (best < 0) begin
      res.push_back(mk(ST_NO_FREE, 0, 0));
    end else if (cache_lock[best]) begin
      res.push_back(mk(ST_VICT_LOCKED, best, 1));
    end else if (cache_dirty[best]) begin
      res.push_back(mk(ST_VICT_DIRTY, best, 1));
    end else begin
      cache_cnt[best] = 8'd1;
      cache_dirty[best] = 0;
      cache_up[best] = 0;
      cache_dev[best] = r.dev;
      cache_blk[best] = r.blk;
      pos = N - 1;
      for (int p = 0; p < N; p++)
        if (lru_order[p] == best) begin
          pos = p;
          break;
        end
      for (int p = pos; p < N - 1; p++) lru_order[p] = lru_order[p + 1];
      lru_order[N - 1] = 6'(best);
      res.push_back(mk(ST_ALLOC, best, 1));
    end
  endtask

  task automatic predict_cache_op(row_t r);
    word_t res[$];
    int i;
    i = r.idx;
    case (r.op)
      OP_GET: cache_get(r, res);
      OP_RELEASE: begin
        if (cache_cnt[i] == 0) res.push_back(mk(ST_REL_ERROR, i, 1));
        else if (cache_lock[i]) res.push_back(mk(ST_REL_BUSY, i, 1));
        else begin
          cache_cnt[i]--;
          res.push_back(mk(ST_RELEASED, i, 1));
        end
      end
      OP_UPDATE: begin
        cache_dirty[i] = r.d;
        cache_lock[i] = r.l;
        cache_up[i] = r.u;
        res.push_back(mk(ST_FLAGS_SET, i, 1));
      end
      OP_INVAL: begin
        if (r.dev != 0)
          for (int e = 0; e < N; e++)
            if (cache_dev[e] == r.dev) begin
              cache_up[e] = 0;
              cache_dirty[e] = 0;
            end
        res.push_back(mk(ST_INVALIDATED, 0, 0));
      end
      OP_SYNC: begin
        for (int e = 0; e < N; e++)
          if (cache_dev[e] != 0 && (r.all || cache_dev[e] == r.dev) && cache_dirty[e])
            res.push_back(mk(ST_DIRTY_ENTRY, e, 1));
        if (res.size() == 0) res.push_back(mk(ST_NONE_DIRTY, 0, 0));
      end
      default: ;
    endcase
    if (res.size() > 0) begin
      res[res.size() - 1].lst = 1;
      if (r.chk && res[0].st != r.st)
        report($sformatf("item %0d status %0d, table says %0d", items_sent, res[0].st, r.st));
    end
    foreach (res[k]) pending_words.push_back(res[k]);
  endtask

  task automatic send(row_t r);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    opcode <= r.op;
    device <= r.dev;
    block_number <= r.blk;
    entry_index <= r.idx;
    all_devices <= r.all;
    new_dirty <= r.d;
    new_locked <= r.l;
    new_uptodate <= r.u;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    predict_cache_op(r);
    items_sent++;
  endtask

  function automatic row_t mkrow(logic [2:0] op, logic [15:0] dev, logic [23:0] blk,
                                 logic [5:0] idx, logic all, logic d, logic l, logic u,
                                 bit chk = 0, status_t st = ST_HIT);
    row_t r;
    r.op = op; r.dev = dev; r.blk = blk; r.idx = idx; r.all = all;
    r.d = d; r.l = l; r.u = u; r.chk = chk; r.st = st;
    return r;
  endfunction

  function automatic row_t rand_row();
    row_t r;
    int k;
    r = mkrow(3'($urandom_range(0, 4)), 16'($urandom_range(1, 3)),
              24'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 9) < 3, 1'($urandom_range(0, 1)));
    k = $urandom_range(0, 99);
    if (k < 45) r.op = OP_GET;
    else if (k < 65) r.op = OP_RELEASE;
    else if (k < 80) r.op = OP_UPDATE;
    else if (k < 88) r.op = OP_INVAL;
    else if (k < 97) r.op = OP_SYNC;
    else r.op = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) r.dev = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 19) == 0) r.dev = 0;
    if ($urandom_range(0, 9) == 0) r.blk = 24'($urandom());
    return r;
  endfunction

  // random receiver stalls in bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    word_t w;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word status %0d index %0d", status, result_index));
      end else begin
        w = pending_words.pop_front();
        if (status !== w.st || result_index !== w.idx || result_uptodate !== w.up ||
            result_locked !== w.lk || last !== w.lst)
          report($sformatf("got st %0d idx %0d up %b lk %b last %b, want %0d %0d %b %b %b",
                           status, result_index, result_uptodate, result_locked, last,
                           w.st, w.idx, w.up, w.lk, w.lst));
      end
    end
  end

  initial begin
    #30000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    for (int e = 0; e < N; e++) begin
      cache_dev[e] = 0; cache_blk[e] = 0; cache_cnt[e] = 0;
      cache_dirty[e] = 0; cache_lock[e] = 0; cache_up[e] = 0;
      lru_order[e] = e;
    end
    table_rows.push_back(mkrow(OP_SYNC, 0, 0, 0, 1, 0, 0, 0, 1, ST_NONE_DIRTY));
    table_rows.push_back(mkrow(OP_GET, 16'hFFFF, 24'hFFFFFF, 0, 0, 0, 0, 0, 1, ST_ALLOC));
    table_rows.push_back(mkrow(OP_GET, 16'hFFFF, 24'hFFFFFF, 0, 0, 0, 0, 0, 1, ST_HIT));
    table_rows.push_back(mkrow(OP_GET, 0, 0, 0, 0, 0, 0, 0, 1, ST_ALLOC));
    table_rows.push_back(mkrow(OP_GET, 0, 0, 0, 0, 0, 0, 0, 1, ST_ALLOC));
    table_rows.push_back(mkrow(OP_RELEASE, 0, 0, 63, 0, 0, 0, 0, 1, ST_REL_ERROR));
    table_rows.push_back(mkrow(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 1, ST_RELEASED));
    table_rows.push_back(mkrow(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 1, ST_RELEASED));
    table_rows.push_back(mkrow(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 1, ST_REL_ERROR));
    table_rows.push_back(mkrow(OP_UPDATE, 0, 0, 5, 0, 1, 1, 1, 1, ST_FLAGS_SET));
    table_rows.push_back(mkrow(OP_UPDATE, 0, 0, 3, 0, 1, 0, 1));
    table_rows.push_back(mkrow(OP_UPDATE, 0, 0, 4, 0, 0, 1, 0));
    table_rows.push_back(mkrow(OP_GET, 7, 1, 0, 0, 0, 0, 0));
    table_rows.push_back(mkrow(OP_UPDATE, 0, 0, 1, 0, 0, 1, 0));
    table_rows.push_back(mkrow(OP_RELEASE, 0, 0, 1, 0, 0, 0, 0, 1, ST_REL_BUSY));
    table_rows.push_back(mkrow(OP_SYNC, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE_DIRTY));
    table_rows.push_back(mkrow(OP_UPDATE, 0, 0, 0, 0, 1, 0, 1));
    table_rows.push_back(mkrow(OP_SYNC, 0, 0, 0, 1, 0, 0, 0, 1, ST_DIRTY_ENTRY));
    table_rows.push_back(mkrow(OP_SYNC, 16'hFFFF, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mkrow(OP_INVAL, 16'hFFFF, 0, 0, 0, 0, 0, 0, 1, ST_INVALIDATED));
    table_rows.push_back(mkrow(OP_INVAL, 0, 0, 0, 0, 0, 0, 0, 1, ST_INVALIDATED));
    table_rows.push_back(mkrow(OP_SYNC, 0, 0, 0, 1, 0, 0, 0, 1, ST_NONE_DIRTY));
    table_rows.push_back(mkrow(3'd5, 1, 1, 1, 1, 1, 1, 1));
    table_rows.push_back(mkrow(3'd7, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mkrow(OP_GET, 16'hAAAA, 24'h555555, 0, 0, 0, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 0;

    foreach (table_rows[k]) send(table_rows[k]);
    repeat (40) send(rand_row());
    // fill every entry so gets run out of victims
    for (int k = 0; k < 66; k++) send(mkrow(OP_GET, 9, 24'(k), 0, 0, 0, 0, 0));
    repeat (15) send(rand_row());
    quiet = 1;
    repeat (15) send(rand_row());
    in_valid <= 0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    $display("sent %0d items (directed, random, fill), checked %0d words",
             items_sent, words_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
